[rtl/c8eu_pkg.sv]
// Shared definitions for the CHIP-8 execute unit: operation codes and fixed constants.
// No dependencies; used by the execute unit and its port checker.

package c8eu_pkg;

   // Dense operation numbering of the decoded instruction stream.
   typedef enum logic [4:0] {
      MODE_NOP          = 5'd0,
      MODE_JUMP         = 5'd1,
      MODE_JUMP_V0      = 5'd2,
      MODE_CALL         = 5'd3,
      MODE_RET          = 5'd4,
      MODE_SKIP_EQ_IMM  = 5'd5,
      MODE_SKIP_EQ_REG  = 5'd6,
      MODE_SKIP_NE_IMM  = 5'd7,
      MODE_SKIP_NE_REG  = 5'd8,
      MODE_LOAD_IMM     = 5'd9,
      MODE_LOAD_REG     = 5'd10,
      MODE_LOAD_INDEX   = 5'd11,
      MODE_GET_DELAY    = 5'd12,
      MODE_SET_DELAY    = 5'd13,
      MODE_SET_SOUND    = 5'd14,
      MODE_ADD_IMM      = 5'd15,
      MODE_ADD_REG      = 5'd16,
      MODE_SUB          = 5'd17,
      MODE_SUBN         = 5'd18,
      MODE_OR           = 5'd19,
      MODE_AND          = 5'd20,
      MODE_XOR          = 5'd21,
      MODE_SHR          = 5'd22,
      MODE_SHL          = 5'd23,
      MODE_RAND         = 5'd24,
      MODE_ADD_INDEX    = 5'd25,
      MODE_BCD          = 5'd26
   } mode_type;

   localparam int          C8EU_STACK_DEPTH = 16;
   localparam logic [3:0]  C8EU_FLAG_REG    = 4'hF;
   localparam logic [15:0] C8EU_PC_STEP     = 16'd2;
   localparam logic [15:0] C8EU_PC_START    = 16'd512;
   localparam logic [7:0]  C8EU_HUNDRED     = 8'd100;
   localparam logic [7:0]  C8EU_TWO_HUNDRED = 8'd200;
   localparam logic [3:0]  C8EU_TEN         = 4'd10;
   // 205 / 2048 approximates 1/10 exactly for every value below 100.
   localparam logic [7:0]  C8EU_DIV10_MUL   = 8'd205;
   localparam int          C8EU_DIV10_SHIFT = 11;
   localparam logic [3:0]  C8EU_DIGIT_MAX   = 4'd9;

endpackage

[rtl/chip8_execute_unit.sv]
// CHIP-8 execute unit: register file, pc, I, return stack and timers, one decoded op per beat.
// Depends on c8eu_pkg for operation codes and constants.
//
//  channel | ports            | direction | handshake
//  --------+------------------+-----------+---------------------------------------
//  request | req_*            | in        | req_valid / req_stall (stall driven here)
//  result  | rsp_*            | out       | rsp_valid / rsp_stall (stall driven by sink)
//  config  | csr_write_*      | in        | csr_write_enable, no wait, loads pc
//
// A beat is held in the input register and executes as it moves to the result register;
// a new beat is taken every cycle while the result side does not stall and no BCD store
// is under way. BCD store holds the execute stage for three result beats, all others one.
// Reset (synchronous) clears V0..VF, I, timers and stack depth and loads pc with 512.
// A stall on the result side backs up into req_stall without losing or repeating a beat.

module chip8_execute_unit
   import c8eu_pkg::*;
#(
   parameter int STACK_DEPTH = C8EU_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_mode,
   input  logic [3:0]  req_reg_x,
   input  logic [3:0]  req_reg_y,
   input  logic [7:0]  req_immediate,
   input  logic [11:0] req_target_address,
   input  logic [7:0]  req_random_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_next_pc,
   output logic [15:0] rsp_index_value,
   output logic        rsp_write_valid,
   output logic [15:0] rsp_write_address,
   output logic [3:0]  rsp_write_data,
   output logic        rsp_stack_fault,
   output logic        rsp_last,

   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);
   localparam logic [DW-1:0] DEPTH_ONE = DW'(1);

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [4:0]  in_mode_ff;
   logic [3:0]  in_x_ff, in_y_ff;
   logic [7:0]  in_imm_ff, in_rnd_ff;
   logic [11:0] in_addr_ff;
   logic [7:0]  vx_ff, vx_in, vy_ff, vy_in;

   // Architectural state.
   logic [7:0]  gpr_ff [16];
   logic [15:0] pc_ff, pc_in;
   logic [15:0] idx_ff, idx_in;
   logic [7:0]  dt_ff, dt_in, st_ff, st_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [15:0] stack_mem [STACK_DEPTH];
   logic [15:0] top_ff;

   // Result register and the pending BCD digits.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_pc_ff, rsp_idx_ff, rsp_waddr_ff;
   logic        rsp_wvalid_ff, rsp_fault_ff, rsp_last_ff;
   logic [3:0]  rsp_wdata_ff;
   logic [1:0]  bcd_left_ff, bcd_left_in;
   logic [3:0]  bcd_tens_ff, bcd_ones_ff;
   logic [15:0] bcd_addr_ff;

   logic accept, out_free, exec_fire, bcd_fire;
   logic [3:0] x_next, y_next;

   // Execute results.
   logic [15:0] pc_new, idx_new, pc_step;
   logic [7:0]  dt_new, st_new, alu_val;
   logic        alu_we, flag_we, flag_val, fault, push, is_bcd;
   logic [DW-1:0] depth_new, depth_m1;
   logic [8:0]  sum9;
   logic [1:0]  hund;
   logic [6:0]  rem;
   logic [14:0] tens_prod;
   logic [3:0]  tens, ones;
   logic [7:0]  tens_x10;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign exec_fire = in_valid_ff && out_free && (bcd_left_ff == 2'd0);
   assign bcd_fire  = (bcd_left_ff != 2'd0) && out_free;
   assign req_stall = in_valid_ff && !exec_fire;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !exec_fire);

   always_comb begin
      pc_step   = pc_ff + C8EU_PC_STEP;
      pc_new    = pc_step;
      idx_new   = idx_ff;
      dt_new    = dt_ff;
      st_new    = st_ff;
      depth_new = depth_ff;
      alu_val   = 8'h00;
      alu_we    = 1'b0;
      flag_we   = 1'b0;
      flag_val  = 1'b0;
      fault     = 1'b0;
      push      = 1'b0;
      is_bcd    = 1'b0;
      sum9      = {1'b0, vx_ff} + {1'b0, vy_ff};
      case (in_mode_ff)
         MODE_JUMP: begin
            pc_new = {4'h0, in_addr_ff};
         end
         MODE_JUMP_V0: begin
            pc_new = {8'h00, gpr_ff[0]} + {4'h0, in_addr_ff};
         end
         MODE_CALL: begin
            if (depth_ff >= DEPTH_MAX) begin
               fault = 1'b1;
            end else begin
               push      = 1'b1;
               depth_new = depth_ff + DEPTH_ONE;
               pc_new    = {4'h0, in_addr_ff};
            end
         end
         MODE_RET: begin
            if (depth_ff == '0) begin
               fault = 1'b1;
            end else begin
               depth_new = depth_ff - DEPTH_ONE;
               pc_new    = top_ff;
            end
         end
         MODE_SKIP_EQ_IMM: begin
            if (vx_ff == in_imm_ff) pc_new = pc_step + C8EU_PC_STEP;
         end
         MODE_SKIP_EQ_REG: begin
            if (vx_ff == vy_ff) pc_new = pc_step + C8EU_PC_STEP;
         end
         MODE_SKIP_NE_IMM: begin
            if (vx_ff != in_imm_ff) pc_new = pc_step + C8EU_PC_STEP;
         end
         MODE_SKIP_NE_REG: begin
            if (vx_ff != vy_ff) pc_new = pc_step + C8EU_PC_STEP;
         end
         MODE_LOAD_IMM: begin
            alu_we  = 1'b1;
            alu_val = in_imm_ff;
         end
         MODE_LOAD_REG: begin
            alu_we  = 1'b1;
            alu_val = vy_ff;
         end
         MODE_LOAD_INDEX: begin
            idx_new = {4'h0, in_addr_ff};
         end
         MODE_GET_DELAY: begin
            alu_we  = 1'b1;
            alu_val = dt_ff;
         end
         MODE_SET_DELAY: begin
            dt_new = vx_ff;
         end
         MODE_SET_SOUND: begin
            st_new = vx_ff;
         end
         MODE_ADD_IMM: begin
            alu_we  = 1'b1;
            alu_val = vx_ff + in_imm_ff;
         end
         MODE_ADD_REG: begin
            alu_we   = 1'b1;
            alu_val  = sum9[7:0];
            flag_we  = 1'b1;
            flag_val = sum9[8];
         end
         MODE_SUB: begin
            alu_we   = 1'b1;
            alu_val  = vx_ff - vy_ff;
            flag_we  = 1'b1;
            flag_val = (vx_ff >= vy_ff);
         end
         MODE_SUBN: begin
            alu_we   = 1'b1;
            alu_val  = vy_ff - vx_ff;
            flag_we  = 1'b1;
            flag_val = (vy_ff >= vx_ff);
         end
         MODE_OR: begin
            alu_we  = 1'b1;
            alu_val = vx_ff | vy_ff;
         end
         MODE_AND: begin
            alu_we  = 1'b1;
            alu_val = vx_ff & vy_ff;
         end
         MODE_XOR: begin
            alu_we  = 1'b1;
            alu_val = vx_ff ^ vy_ff;
         end
         MODE_SHR: begin
            alu_we   = 1'b1;
            alu_val  = {1'b0, vx_ff[7:1]};
            flag_we  = 1'b1;
            flag_val = vx_ff[0];
         end
         MODE_SHL: begin
            alu_we   = 1'b1;
            alu_val  = {vx_ff[6:0], 1'b0};
            flag_we  = 1'b1;
            flag_val = vx_ff[7];
         end
         MODE_RAND: begin
            alu_we  = 1'b1;
            alu_val = in_rnd_ff & in_imm_ff;
         end
         MODE_ADD_INDEX: begin
            idx_new = idx_ff + {8'h00, vx_ff};
         end
         MODE_BCD: begin
            is_bcd = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Decimal digits of Vx: compare for hundreds, reciprocal multiply for tens.
   always_comb begin
      if (vx_ff >= C8EU_TWO_HUNDRED) begin
         hund = 2'd2;
         rem  = 7'(vx_ff - C8EU_TWO_HUNDRED);
      end else if (vx_ff >= C8EU_HUNDRED) begin
         hund = 2'd1;
         rem  = 7'(vx_ff - C8EU_HUNDRED);
      end else begin
         hund = 2'd0;
         rem  = vx_ff[6:0];
      end
      tens_prod = {8'h00, rem} * {7'h00, C8EU_DIV10_MUL};
      tens      = 4'(tens_prod >> C8EU_DIV10_SHIFT);
      tens_x10  = {4'h0, tens} * {4'h0, C8EU_TEN};
      ones      = 4'({1'b0, rem} - tens_x10);
   end

   // Operand registers track the register file, including this cycle's write-back.
   assign x_next = accept ? req_reg_x : in_x_ff;
   assign y_next = accept ? req_reg_y : in_y_ff;

   always_comb begin
      vx_in = gpr_ff[x_next];
      if (exec_fire && alu_we && (x_next == in_x_ff)) vx_in = alu_val;
      if (exec_fire && flag_we && (x_next == C8EU_FLAG_REG)) vx_in = {7'h00, flag_val};
      vy_in = gpr_ff[y_next];
      if (exec_fire && alu_we && (y_next == in_x_ff)) vy_in = alu_val;
      if (exec_fire && flag_we && (y_next == C8EU_FLAG_REG)) vy_in = {7'h00, flag_val};
   end

   always_comb begin
      if (csr_write_enable) begin
         pc_in = {4'h0, csr_write_data};
      end else if (exec_fire) begin
         pc_in = pc_new;
      end else begin
         pc_in = pc_ff;
      end
      idx_in   = exec_fire ? idx_new : idx_ff;
      dt_in    = exec_fire ? dt_new : dt_ff;
      st_in    = exec_fire ? st_new : st_ff;
      depth_in = exec_fire ? depth_new : depth_ff;
   end

   // The top of stack is kept in a register, refilled from the stack memory.
   assign depth_m1 = depth_in - DEPTH_ONE;

   always_ff @(posedge clock) begin
      if (exec_fire && push) begin
         stack_mem[depth_ff[AW-1:0]] <= pc_step;
         top_ff <= pc_step;
      end else if (depth_in != '0) begin
         top_ff <= stack_mem[depth_m1[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pc_ff       <= C8EU_PC_START;
         idx_ff      <= 16'h0000;
         dt_ff       <= 8'h00;
         st_ff       <= 8'h00;
         depth_ff    <= '0;
         for (int i = 0; i < 16; i++) begin
            gpr_ff[i] <= 8'h00;
         end
      end else begin
         in_valid_ff <= in_valid_in;
         pc_ff       <= pc_in;
         idx_ff      <= idx_in;
         dt_ff       <= dt_in;
         st_ff       <= st_in;
         depth_ff    <= depth_in;
         if (exec_fire && alu_we) gpr_ff[in_x_ff] <= alu_val;
         // The flag lands after the result, so it wins when x is VF.
         if (exec_fire && flag_we) gpr_ff[C8EU_FLAG_REG] <= {7'h00, flag_val};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff <= req_mode;
         in_x_ff    <= req_reg_x;
         in_y_ff    <= req_reg_y;
         in_imm_ff  <= req_immediate;
         in_addr_ff <= req_target_address;
         in_rnd_ff  <= req_random_byte;
      end
      vx_ff <= vx_in;
      vy_ff <= vy_in;
   end

   // Result register and the BCD beat sequencer.
   assign rsp_valid_in = exec_fire || bcd_fire || (rsp_valid_ff && rsp_stall);

   always_comb begin
      bcd_left_in = bcd_left_ff;
      if (exec_fire && is_bcd) begin
         bcd_left_in = 2'd2;
      end else if (bcd_fire) begin
         bcd_left_in = bcd_left_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         bcd_left_ff  <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         bcd_left_ff  <= bcd_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_pc_ff     <= pc_new;
         rsp_idx_ff    <= idx_new;
         rsp_fault_ff  <= fault;
         rsp_wvalid_ff <= is_bcd;
         rsp_waddr_ff  <= is_bcd ? idx_ff : 16'h0000;
         rsp_wdata_ff  <= is_bcd ? {2'b00, hund} : 4'h0;
         rsp_last_ff   <= !is_bcd;
         bcd_tens_ff   <= tens;
         bcd_ones_ff   <= ones;
         bcd_addr_ff   <= idx_ff + 16'd1;
      end else if (bcd_fire) begin
         rsp_waddr_ff <= bcd_addr_ff;
         bcd_addr_ff  <= bcd_addr_ff + 16'd1;
         if (bcd_left_ff == 2'd2) begin
            rsp_wdata_ff <= bcd_tens_ff;
            rsp_last_ff  <= 1'b0;
         end else begin
            rsp_wdata_ff <= bcd_ones_ff;
            rsp_last_ff  <= 1'b1;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_pc       = rsp_pc_ff;
   assign rsp_index_value   = rsp_idx_ff;
   assign rsp_write_valid   = rsp_wvalid_ff;
   assign rsp_write_address = rsp_waddr_ff;
   assign rsp_write_data    = rsp_wdata_ff;
   assign rsp_stack_fault   = rsp_fault_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

[rtl/c8eu_checker.sv]
// Port-level checks on the result channel of the CHIP-8 execute unit, bound to the top level.
// Depends on c8eu_pkg for the largest decimal digit.

module c8eu_checker
   import c8eu_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_next_pc,
   input logic [15:0] rsp_index_value,
   input logic        rsp_write_valid,
   input logic [15:0] rsp_write_address,
   input logic [3:0]  rsp_write_data,
   input logic        rsp_stack_fault,
   input logic        rsp_last
);

   // A stalled beat stays put.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_pc)
         && $stable(rsp_write_address) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // Only BCD beats carry writes; every other operation is a single, final beat.
   a_plain_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_valid |-> rsp_last && (rsp_write_address == 16'h0000)
         && (rsp_write_data == 4'h0))
      else $error("beat without a write is not a clean final beat");

   a_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |-> (rsp_write_data <= C8EU_DIGIT_MAX) && !rsp_stack_fault)
      else $error("BCD beat carries a bad digit or a stack fault");

   // Once a non-final BCD beat is taken, the next digit follows at once at the next address.
   a_bcd_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_write_valid && !rsp_last |=>
         rsp_valid && rsp_write_valid
         && (rsp_write_address == 16'($past(rsp_write_address) + 16'd1))
         && (rsp_next_pc == $past(rsp_next_pc))
         && (rsp_index_value == $past(rsp_index_value)))
      else $error("BCD digit sequence broken");

endmodule

bind chip8_execute_unit c8eu_checker u_c8eu_checker (.*);
